/* rtl/core/csvfs_pkg.sv */
// Shared types and constants for the CSV field splitter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package csvfs_pkg;

    localparam int MAX_FIELDS_DEF = 256;
    localparam int QDEPTH         = 2;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int QCNT_W         = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_PLAIN   = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_QSEEN   = 3'd3,
        MODE_LITERAL = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_FIELD_END = 2'd1,
        KIND_LINE_END  = 2'd2,
        KIND_EMPTY     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CL_OTHER = 3'd0,
        CL_COMMA = 3'd1,
        CL_QUOTE = 3'd2,
        CL_CR    = 3'd3,
        CL_LF    = 3'd4,
        CL_EOS   = 3'd5
    } t_class;

    // one classified word between front and back
    typedef struct packed {
        t_class     cls;
        logic [7:0] data;
    } t_word;

endpackage

`default_nettype wire

/* rtl/core/csv_field_splitter.sv */
// An accepted byte passes the front register, the queue and the result register in turn.
// Throughput: one byte per cycle while the output accepts results, set by the parse state update.
// Front register, two-entry queue and result register each stall on their own.
// Reset (synchronous, active low) empties every stage and returns the parser
// to the start of a line with field number zero.
`default_nettype none

module csv_field_splitter #(
    parameter int MAX_FIELDS = csvfs_pkg::MAX_FIELDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_stream,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_field_number
);
    import csvfs_pkg::*;

    logic  f_valid, f_ready;
    t_word f_word;
    logic  q_valid, q_ready;
    t_word q_word;

    csvfs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (f_valid),
        .i_ready         (f_ready),
        .o_word          (f_word)
    );

    csvfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_word  (f_word),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_word  (q_word)
    );

    csvfs_back #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_ready        (q_ready),
        .i_word         (q_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_kind         (o_kind),
        .o_field_number (o_field_number)
    );

endmodule

`default_nettype wire

/* rtl/core/csvfs_front.sv */
// Front end: accepts input words and classifies each byte.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_end_of_stream,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output csvfs_pkg::t_word      o_word
);
    import csvfs_pkg::*;

    logic  r_valid;
    t_word r_word;
    t_word n_word;
    logic  take;

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    always_comb begin
        n_word.data = i_data_byte;
        priority if (i_end_of_stream) begin
            n_word.cls = CL_EOS;
        end else if (i_data_byte == CH_COMMA) begin
            n_word.cls = CL_COMMA;
        end else if (i_data_byte == CH_QUOTE) begin
            n_word.cls = CL_QUOTE;
        end else if (i_data_byte == CH_CR) begin
            n_word.cls = CL_CR;
        end else if (i_data_byte == CH_LF) begin
            n_word.cls = CL_LF;
        end else begin
            n_word.cls = CL_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csvfs_queue.sv */
// Short register queue decoupling the front end from the parser.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  csvfs_pkg::t_word      i_word,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output csvfs_pkg::t_word      o_word
);
    import csvfs_pkg::*;

    t_word              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic               push;
    logic               pop;

    assign o_ready = r_count != QCNT_W'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_word  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = i_ready && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_word;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csvfs_back.sv */
// Back end: CSV parse state machine and registered result stage.
// Depends on csvfs_pkg.
`default_nettype none

module csvfs_back #(
    parameter int MAX_FIELDS = csvfs_pkg::MAX_FIELDS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  csvfs_pkg::t_word      i_word,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [7:0]            o_out_byte,
    output logic [1:0]            o_kind,
    output logic [7:0]            o_field_number
);
    import csvfs_pkg::*;

    localparam logic [7:0] FIELD_CAP =
        ((MAX_FIELDS - 1) > 255) ? 8'd255 : 8'(MAX_FIELDS - 1);

    t_mode       r_mode, n_mode;
    logic        r_acr, n_acr;
    logic        r_started, n_started;
    logic [7:0]  r_index, n_index;

    logic        r_o_valid;
    logic [7:0]  r_o_byte;
    t_kind       r_o_kind;
    logic [7:0]  r_o_num;

    logic        emit;
    logic [7:0]  e_byte;
    t_kind       e_kind;
    logic [7:0]  e_num;
    logic        pop;

    assign o_ready        = !r_o_valid || i_ready;
    assign pop            = i_valid && o_ready;
    assign o_valid        = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_kind         = r_o_kind;
    assign o_field_number = r_o_num;

    always_comb begin
        n_mode    = r_mode;
        n_acr     = 1'b0;
        n_started = r_started;
        n_index   = r_index;
        emit      = 1'b0;
        e_byte    = '0;
        e_kind    = KIND_DATA;
        e_num     = r_index;

        priority if (i_word.cls == CL_EOS) begin
            emit      = r_started;
            e_kind    = KIND_LINE_END;
            n_mode    = MODE_START;
            n_index   = '0;
            n_started = 1'b0;
        end else if (r_acr && i_word.cls == CL_LF) begin
            // LF of a CR LF pair
        end else if (i_word.cls == CL_CR || i_word.cls == CL_LF) begin
            n_acr     = i_word.cls == CL_CR;
            emit      = 1'b1;
            e_kind    = r_started ? KIND_LINE_END : KIND_EMPTY;
            e_num     = r_started ? r_index : '0;
            n_mode    = MODE_START;
            n_index   = '0;
            n_started = 1'b0;
        end else begin
            n_started = 1'b1;
            emit      = 1'b1;
            e_byte    = i_word.data;
            unique case (r_mode)
                MODE_START: begin
                    unique case (i_word.cls)
                        CL_QUOTE: begin
                            emit   = 1'b0;
                            e_byte = '0;
                            n_mode = MODE_QUOTED;
                        end
                        CL_COMMA: begin
                            e_byte = '0;
                        end
                        default: begin
                            n_mode = MODE_PLAIN;
                        end
                    endcase
                end
                MODE_QUOTED: begin
                    if (i_word.cls == CL_QUOTE) begin
                        emit   = 1'b0;
                        e_byte = '0;
                        n_mode = MODE_QSEEN;
                    end
                end
                MODE_QSEEN: begin
                    unique case (i_word.cls)
                        CL_QUOTE: begin
                            n_mode = MODE_QUOTED;
                        end
                        CL_COMMA: begin
                            e_byte = '0;
                        end
                        default: begin
                            n_mode = MODE_LITERAL;
                        end
                    endcase
                end
                default: begin
                    if (i_word.cls == CL_COMMA) begin
                        e_byte = '0;
                    end
                end
            endcase
            if (i_word.cls == CL_COMMA && !(r_mode == MODE_QUOTED)) begin
                e_kind = KIND_FIELD_END;
                n_mode = MODE_START;
                if (r_index < FIELD_CAP) begin
                    n_index = r_index + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_acr     <= 1'b0;
            r_started <= 1'b0;
            r_index   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_mode    <= n_mode;
                r_acr     <= n_acr;
                r_started <= n_started;
                r_index   <= n_index;
                r_o_valid <= emit;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && emit) begin
            r_o_byte <= e_byte;
            r_o_kind <= e_kind;
            r_o_num  <= e_num;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csvfs_checker.sv */
// Port-level checks for the CSV field splitter, bound to the top level.
// Depends on csvfs_pkg and csv_field_splitter.
`default_nettype none

module csvfs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [7:0]  o_out_byte,
    input wire logic [1:0]  o_kind,
    input wire logic [7:0]  o_field_number
);
    import csvfs_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_kind)
                                   && $stable(o_out_byte) && $stable(o_field_number)))
        else $error("result dropped while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_EMPTY) |-> (o_field_number == 8'd0 && o_out_byte == 8'd0))
        else $error("empty line mark carries data");

    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == KIND_FIELD_END || o_kind == KIND_LINE_END))
            |-> (o_out_byte == 8'd0))
        else $error("boundary mark carries a byte");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result after reset");

endmodule

bind csv_field_splitter csvfs_checker u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_out_byte     (o_out_byte),
    .o_kind         (o_kind),
    .o_field_number (o_field_number)
);

`default_nettype wire
